FILE: rtl/core/mts_pkg.sv
// Shared types and constants for the multi-timer scheduler.
// No dependencies; imported by every other file of the block but mts_if.
package mts_pkg;

	localparam int TIMER_SLOTS_DEF = 16;
	localparam int QUEUE_DEPTH     = 2;

	typedef enum logic [1:0] {
		CMD_SET    = 2'd0,
		CMD_CANCEL = 2'd1,
		CMD_TICK   = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_SET_ACK    = 2'd0,
		KIND_CANCEL_ACK = 2'd1,
		KIND_FIRE       = 2'd2,
		KIND_DONE       = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STS_OK         = 2'd0,
		STS_ZERO_DELAY = 2'd1,
		STS_NO_SLOT    = 2'd2,
		STS_NOT_FOUND  = 2'd3
	} status_t;

	// request class decided at the front end
	typedef enum logic [2:0] {
		CLS_SET,
		CLS_SET_ZERO,
		CLS_CANCEL,
		CLS_CANCEL_NONE,
		CLS_TICK
	} cls_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} eng_state_t;

	typedef struct packed {
		cls_t        cls;
		logic [31:0] delay;
		logic        periodic;
		logic        stage;
		logic [31:0] timer_id;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} q_link_t;

	typedef struct packed {
		logic [31:0] ident;
		logic [31:0] due;
		logic [31:0] period;
		logic        stage;
	} slot_t;

	typedef struct packed {
		kind_t       kind;
		status_t     status;
		logic [31:0] result_id;
		logic        fired_stage;
		logic [4:0]  fired_count;
		logic [31:0] now_tick;
		logic        last;
	} res_t;

endpackage

FILE: rtl/core/mts_if.sv
// Handshake channels of the multi-timer scheduler: request and result.
// Stand-alone; no package needed.
interface mts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] delay;
	logic        periodic;
	logic        stage;
	logic [31:0] timer_id;

	modport source (output valid, command, delay, periodic, stage, timer_id, input ready);
	modport sink   (input valid, command, delay, periodic, stage, timer_id, output ready);
endinterface

interface mts_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  status;
	logic [31:0] result_id;
	logic        fired_stage;
	logic [4:0]  fired_count;
	logic [31:0] now_tick;
	logic        last;

	modport source (output valid, kind, status, result_id, fired_stage, fired_count,
		now_tick, last, input ready);
	modport sink   (input valid, kind, status, result_id, fired_stage, fired_count,
		now_tick, last, output ready);
endinterface

FILE: rtl/core/mts_front.sv
// Front end: takes requests, classifies them, holds them in a short queue.
// Depends on mts_pkg and mts_req_if.
module mts_front
	import mts_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	mts_req_if.sink       req,
	output q_link_t       link,
	input  logic          pop
);

	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t              q_mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              keep;
	logic              push, do_pop;
	job_t              job_in;

	assign req.ready = (cnt_q != QCNT_W'(QUEUE_DEPTH));

	// classification; unused command code is accepted and dropped
	always_comb begin
		job_in          = '0;
		job_in.delay    = req.delay;
		job_in.periodic = req.periodic;
		job_in.stage    = req.stage;
		job_in.timer_id = req.timer_id;
		keep            = 1'b1;
		case (req.command)
			CMD_SET:    job_in.cls = (req.delay == 32'd0) ? CLS_SET_ZERO : CLS_SET;
			CMD_CANCEL: job_in.cls = (req.timer_id == 32'd0) ? CLS_CANCEL_NONE : CLS_CANCEL;
			CMD_TICK:   job_in.cls = CLS_TICK;
			default: begin
				job_in.cls = CLS_TICK;
				keep       = 1'b0;
			end
		endcase
	end

	assign push   = req.valid && req.ready && keep;
	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (!push && do_pop)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			q_mem[wr_ptr_q] <= job_in;
	end

	assign link.valid = (cnt_q != '0);
	assign link.job   = q_mem[rd_ptr_q];

endmodule

FILE: rtl/core/mts_engine.sv
// Back end: slot table, tick counter and slot-serial scan that produces results.
// Depends on mts_pkg and mts_rsp_if; fed by mts_front.
module mts_engine
	import mts_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  q_link_t       link,
	output logic          pop,
	mts_rsp_if.source     rsp
);

	localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

	eng_state_t              state_q, state_d;
	job_t                    job_q;
	logic [IDX_W-1:0]        idx_q, raddr;
	logic                    pass_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [31:0]             tick_q, next_id_q, new_id;
	logic [TIMER_SLOTS-1:0]  valid_q;
	slot_t                   mem [TIMER_SLOTS];
	slot_t                   rdata_q;
	logic                    out_valid_q;
	res_t                    out_q;

	logic   out_free, last_idx, hit, step;
	logic   emit, wr_en, set_valid, clr_valid;
	slot_t  wr_entry;
	res_t   res;

	assign out_free = !out_valid_q || rsp.ready;
	assign last_idx = (idx_q == IDX_W'(TIMER_SLOTS - 1));
	assign new_id   = ((next_id_q + 32'd1) == 32'd0) ? 32'd1 : next_id_q + 32'd1;

	always_comb begin
		case (job_q.cls)
			CLS_SET:    hit = !valid_q[idx_q];
			CLS_CANCEL: hit = valid_q[idx_q] && (rdata_q.ident == job_q.timer_id);
			CLS_TICK:   hit = valid_q[idx_q] && (rdata_q.due == tick_q) &&
				(rdata_q.stage == pass_q);
			default:    hit = 1'b0;
		endcase
	end

	assign step = (state_q == ST_SCAN) && !(hit && !out_free);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (link.valid)
					state_d = (link.job.cls == CLS_SET_ZERO || link.job.cls == CLS_CANCEL_NONE)
						? ST_FINISH : ST_SCAN;
			end
			ST_SCAN: begin
				if (step) begin
					if (hit && job_q.cls != CLS_TICK)
						state_d = ST_IDLE;
					else if (last_idx && !(job_q.cls == CLS_TICK && !pass_q))
						state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop       = 1'b0;
		emit      = 1'b0;
		wr_en     = 1'b0;
		set_valid = 1'b0;
		clr_valid = 1'b0;
		wr_entry  = rdata_q;
		raddr     = '0;
		res           = '0;
		res.now_tick  = tick_q;
		case (state_q)
			ST_IDLE: begin
				pop = link.valid;
			end
			ST_SCAN: begin
				raddr = step ? (last_idx ? '0 : idx_q + 1'b1) : idx_q;
				if (hit && out_free) begin
					emit = 1'b1;
					case (job_q.cls)
						CLS_SET: begin
							res.kind        = KIND_SET_ACK;
							res.result_id   = new_id;
							res.last        = 1'b1;
							wr_en           = 1'b1;
							set_valid       = 1'b1;
							wr_entry.ident  = new_id;
							wr_entry.due    = tick_q + job_q.delay;
							wr_entry.period = job_q.periodic ? job_q.delay : 32'd0;
							wr_entry.stage  = job_q.stage;
						end
						CLS_CANCEL: begin
							res.kind  = KIND_CANCEL_ACK;
							res.last  = 1'b1;
							clr_valid = 1'b1;
						end
						default: begin
							res.kind        = KIND_FIRE;
							res.result_id   = rdata_q.ident;
							res.fired_stage = pass_q;
							if (rdata_q.period != 32'd0) begin
								wr_en        = 1'b1;
								wr_entry.due = tick_q + rdata_q.period;
							end else begin
								clr_valid = 1'b1;
							end
						end
					endcase
				end
			end
			ST_FINISH: begin
				emit     = out_free;
				res.last = 1'b1;
				case (job_q.cls)
					CLS_SET: begin
						res.kind   = KIND_SET_ACK;
						res.status = STS_NO_SLOT;
					end
					CLS_SET_ZERO: begin
						res.kind   = KIND_SET_ACK;
						res.status = STS_ZERO_DELAY;
					end
					CLS_TICK: begin
						res.kind        = KIND_DONE;
						res.fired_count = 5'(cnt_q);
					end
					default: begin
						res.kind   = KIND_CANCEL_ACK;
						res.status = STS_NOT_FOUND;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			pass_q      <= 1'b0;
			cnt_q       <= '0;
			tick_q      <= '0;
			next_id_q   <= '0;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop) begin
				idx_q  <= '0;
				pass_q <= 1'b0;
				cnt_q  <= '0;
				if (link.job.cls == CLS_TICK)
					tick_q <= tick_q + 32'd1;
			end else if (step) begin
				idx_q <= last_idx ? '0 : idx_q + 1'b1;
				if (last_idx)
					pass_q <= 1'b1;
				if (hit && job_q.cls == CLS_TICK)
					cnt_q <= cnt_q + 1'b1;
				if (hit && job_q.cls == CLS_SET)
					next_id_q <= new_id;
			end
			if (set_valid)
				valid_q[idx_q] <= 1'b1;
			if (clr_valid)
				valid_q[idx_q] <= 1'b0;
			if (emit)
				out_valid_q <= 1'b1;
			else if (rsp.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= link.job;
		if (emit)
			out_q <= res;
	end

	// slot memory: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[idx_q] <= wr_entry;
		rdata_q <= mem[raddr];
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.kind        = out_q.kind;
	assign rsp.status      = out_q.status;
	assign rsp.result_id   = out_q.result_id;
	assign rsp.fired_stage = out_q.fired_stage;
	assign rsp.fired_count = out_q.fired_count;
	assign rsp.now_tick    = out_q.now_tick;
	assign rsp.last        = out_q.last;

endmodule

FILE: rtl/core/multi_timer_scheduler_core.sv
// Multi-timer scheduler: TIMER_SLOTS one-shot or periodic timers driven by set, cancel and
// tick requests. Each request is queued (two deep) by the front end, so requests are taken
// while the back end works and while a result waits in the output register. The back end
// handles one request at a time and walks the slot table through the single read port of
// the slot memory, one slot per cycle while the result side does not stall: a set or
// cancel stops at the first free or matching slot, a zero-delay set or a cancel of id
// zero is settled without a scan, and a tick makes two passes over the table (immediate
// stage, then deferred).
// Depends on mts_pkg, mts_if, mts_front and mts_engine.
module multi_timer_scheduler_core
	import mts_pkg::*;
#(
	parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);

	// front to back: head of the request queue and its pop strobe
	q_link_t link;
	logic    pop;

	// classification: zero delay and cancel of id zero are settled without a scan;
	// the unused command code is swallowed here and gives no result
	mts_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.link   (link),
		.pop    (pop)
	);

	// slot table, tick and id counters, result register
	mts_engine #(
		.TIMER_SLOTS (TIMER_SLOTS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.link   (link),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

FILE: rtl/core/mts_checker.sv
// Port-level checks for the multi-timer scheduler, bound to the top level.
// Depends on mts_pkg and multi_timer_scheduler_core.
module mts_checker
	import mts_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [1:0]  rsp_kind,
	input logic [1:0]  rsp_status,
	input logic [31:0] rsp_result_id,
	input logic [4:0]  rsp_fired_count,
	input logic [31:0] rsp_now_tick,
	input logic        rsp_last
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_id) &&
			$stable(rsp_kind) && $stable(rsp_now_tick))
		else $error("result changed while stalled");

	// nothing shown while in reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result valid during reset");

	// a fire is never the final result and carries no count or error
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_FIRE |->
			!rsp_last && rsp_status == STS_OK && rsp_fired_count == 5'd0)
		else $error("malformed fire result");

	// results of one tick share its counter value
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_ready && rsp_kind == KIND_FIRE ##1 rsp_valid |->
			rsp_now_tick == $past(rsp_now_tick) &&
			(rsp_kind == KIND_FIRE || rsp_kind == KIND_DONE))
		else $error("tick results out of sequence");

	// refused set carries no identifier
	a_set: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind == KIND_SET_ACK && rsp_status != STS_OK |->
			rsp_result_id == 32'd0 && rsp_last)
		else $error("refused set with identifier");

endmodule

bind multi_timer_scheduler_core mts_checker u_mts_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_kind        (rsp.kind),
	.rsp_status      (rsp.status),
	.rsp_result_id   (rsp.result_id),
	.rsp_fired_count (rsp.fired_count),
	.rsp_now_tick    (rsp.now_tick),
	.rsp_last        (rsp.last)
);

FILE: test/multi_timer_scheduler_core_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for multi_timer_scheduler_core: request and result channels,
// a shadow timer table predicting every result. Needs mts_pkg, mts_if and the core RTL.
module multi_timer_scheduler_core_test
	import mts_pkg::*;
;

	localparam int SLOTS       = TIMER_SLOTS_DEF;
	localparam int STALL_LIMIT = 3000;	// cycles with no request and no result taken
	localparam int DRAIN_WAIT  = 100;	// wait for late results before the verdict
	localparam int RANDOM_REQS = 24;	// per phase, ignored requests not counted

	// command code the block accepts and ignores
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	// Shadow of the timer table. Requests are noted in acceptance order, which is
	// also the order the block serves them, so the state here is always current
	// for choosing the next request.
	class timer_shadow;
		logic [31:0] now;
		logic [31:0] last_id;
		bit          live[SLOTS];
		logic [31:0] ident[SLOTS];
		logic [31:0] due_at[SLOTS];
		logic [31:0] period[SLOTS];
		logic        stg[SLOTS];
		res_t        awaited_results[$];
		int          errors;

		function new();
			now     = '0;
			last_id = '0;
			errors  = 0;
			foreach (live[i])
				live[i] = 1'b0;
		endfunction

		task report(string msg);
			errors++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		function void push_result(kind_t k, status_t s, logic [31:0] id, logic fs,
				logic [4:0] cnt, logic lst);
			res_t r;
			r.kind        = k;
			r.status      = s;
			r.result_id   = id;
			r.fired_stage = fs;
			r.fired_count = cnt;
			r.now_tick    = now;
			r.last        = lst;
			awaited_results.push_back(r);
		endfunction

		function int live_total();
			int n;
			n = 0;
			foreach (live[i])
				if (live[i])
					n++;
			return n;
		endfunction

		// identifier of a random live timer, zero when the table is empty
		function logic [31:0] any_live_id();
			int start;
			start = $urandom_range(SLOTS - 1);
			for (int k = 0; k < SLOTS; k++)
				if (live[(start + k) % SLOTS])
					return ident[(start + k) % SLOTS];
			return '0;
		endfunction

		function void note_request(logic [1:0] command, logic [31:0] delay, logic periodic,
				logic stage, logic [31:0] timer_id);
			int          slot;
			int          fired;
			logic [31:0] id;
			bit          due_now[SLOTS];
			slot  = -1;
			fired = 0;
			if (command == CMD_SET) begin
				if (delay == 0) begin
					push_result(KIND_SET_ACK, STS_ZERO_DELAY, '0, 1'b0, '0, 1'b1);
					return;
				end
				for (int i = SLOTS - 1; i >= 0; i--)
					if (!live[i])
						slot = i;
				if (slot < 0) begin
					push_result(KIND_SET_ACK, STS_NO_SLOT, '0, 1'b0, '0, 1'b1);
					return;
				end
				id = last_id + 1;
				if (id == 0)
					id = 1;
				last_id      = id;
				live[slot]   = 1'b1;
				ident[slot]  = id;
				due_at[slot] = now + delay;
				period[slot] = periodic ? delay : '0;
				stg[slot]    = stage;
				push_result(KIND_SET_ACK, STS_OK, id, 1'b0, '0, 1'b1);
			end else if (command == CMD_CANCEL) begin
				if (timer_id != 0)
					for (int i = 0; i < SLOTS && slot < 0; i++)
						if (live[i] && ident[i] == timer_id)
							slot = i;
				if (slot >= 0) begin
					live[slot] = 1'b0;
					push_result(KIND_CANCEL_ACK, STS_OK, '0, 1'b0, '0, 1'b1);
				end else begin
					push_result(KIND_CANCEL_ACK, STS_NOT_FOUND, '0, 1'b0, '0, 1'b1);
				end
			end else if (command == CMD_TICK) begin
				now++;
				foreach (live[i])
					due_now[i] = live[i] && due_at[i] == now;
				for (int pass = 0; pass < 2; pass++)
					for (int i = 0; i < SLOTS; i++) begin
						if (due_now[i] && stg[i] == pass) begin
							push_result(KIND_FIRE, STS_OK, ident[i], stg[i], '0, 1'b0);
							fired++;
							if (period[i] != 0)
								due_at[i] = now + period[i];
							else
								live[i] = 1'b0;
						end
					end
				push_result(KIND_DONE, STS_OK, '0, 1'b0, fired[4:0], 1'b1);
			end
		endfunction

		task check_result(res_t got);
			res_t want;
			if (awaited_results.size() == 0) begin
				report($sformatf("result with nothing awaited: kind %0d id %0d",
					got.kind, got.result_id));
				return;
			end
			want = awaited_results.pop_front();
			if (got.kind !== want.kind)
				report($sformatf("kind %0d, want %0d", got.kind, want.kind));
			if (got.status !== want.status)
				report($sformatf("status %0d, want %0d", got.status, want.status));
			if (got.result_id !== want.result_id)
				report($sformatf("result_id %0d, want %0d", got.result_id, want.result_id));
			if (got.fired_stage !== want.fired_stage)
				report($sformatf("fired_stage %0d, want %0d", got.fired_stage,
					want.fired_stage));
			if (got.fired_count !== want.fired_count)
				report($sformatf("fired_count %0d, want %0d", got.fired_count,
					want.fired_count));
			if (got.now_tick !== want.now_tick)
				report($sformatf("now_tick %0d, want %0d", got.now_tick, want.now_tick));
			if (got.last !== want.last)
				report($sformatf("last %0d, want %0d", got.last, want.last));
		endtask
	endclass

	logic clk;
	logic arst_n;
	int   idle_pct;		// chance in a hundred that the sender idles a cycle
	int   stall_pct;	// chance in a hundred that the receiver holds ready low
	int   quiet_cycles;

	timer_shadow sb;

	mts_req_if req_ch();
	mts_rsp_if rsp_ch();

	multi_timer_scheduler_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #4 clk = ~clk;

	// Result side: outputs are read straight after the edge, so they still hold
	// the values that the block saw at that edge. ready is redrawn every cycle.
	always @(posedge clk) begin : result_side
		res_t got;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.kind        = kind_t'(rsp_ch.kind);
			got.status      = status_t'(rsp_ch.status);
			got.result_id   = rsp_ch.result_id;
			got.fired_stage = rsp_ch.fired_stage;
			got.fired_count = rsp_ch.fired_count;
			got.now_tick    = rsp_ch.now_tick;
			got.last        = rsp_ch.last;
			sb.check_result(got);
		end
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: ends the run once nothing has moved on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no progress, %0d results still awaited",
				sb.awaited_results.size());
			$display("multi_timer_scheduler_core_test: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// One request: random idle cycles first, then hold valid until it is taken.
	task automatic send(logic [1:0] command, logic [31:0] delay, logic periodic,
			logic stage, logic [31:0] timer_id);
		while ($urandom_range(99) < idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.command  <= command;
		req_ch.delay    <= delay;
		req_ch.periodic <= periodic;
		req_ch.stage    <= stage;
		req_ch.timer_id <= timer_id;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(command, delay, periodic, stage, timer_id);
	endtask

	// Sender holds off until the block has handed back every awaited result.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (sb.awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// Empty the table, arm every slot for the next tick and tick twice: the first
	// tick fires the whole table, the second only the periodic survivors.
	task automatic fire_whole_table();
		while (sb.live_total() != 0)
			send(CMD_CANCEL, $urandom(), 1'($urandom()), 1'($urandom()), sb.any_live_id());
		repeat (SLOTS)
			send(CMD_SET, 32'd1, 1'($urandom()), 1'($urandom()), $urandom());
		repeat (2)
			send(CMD_TICK, $urandom(), 1'($urandom()), 1'($urandom()), $urandom());
	endtask

	initial begin
		int          n;
		int          pick;
		logic [1:0]  command;
		logic [31:0] delay;
		logic [31:0] timer_id;

		sb              = new();
		clk             = 1'b0;
		arst_n          = 1'b0;
		idle_pct        = 0;
		stall_pct       = 0;
		quiet_cycles    = 0;
		req_ch.valid    = 1'b0;
		req_ch.command  = CMD_SET;
		req_ch.delay    = '0;
		req_ch.periodic = 1'b0;
		req_ch.stage    = 1'b0;
		req_ch.timer_id = '0;
		rsp_ch.ready    = 1'b0;
		repeat (10)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		send(CMD_SET, 32'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);	// zero delay refused
		send(CMD_CANCEL, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0);	// id zero never exists
		send(CMD_CANCEL, 32'd0, 1'b0, 1'b0, 32'hFFFF_FFFF);	// unknown id
		send(CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF);	// ignored
		send(CMD_TICK, 32'd0, 1'b0, 1'b0, 32'd0);		// empty table, count zero
		// fill the table: a few near timers in both stages, periodic and one-shot,
		// the rest far in the future
		send(CMD_SET, 32'd1, 1'b0, 1'b1, 32'd0);
		send(CMD_SET, 32'd1, 1'b0, 1'b0, 32'd0);
		send(CMD_SET, 32'd2, 1'b1, 1'b1, 32'd0);
		send(CMD_SET, 32'd1, 1'b1, 1'b0, 32'd0);
		send(CMD_SET, 32'd3, 1'b1, 1'b0, 32'd0);
		send(CMD_SET, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'd0);
		for (int i = 6; i < SLOTS; i++)
			send(CMD_SET, $urandom() | 32'h100, 1'($urandom()), 1'($urandom()),
				$urandom());
		send(CMD_SET, 32'd5, 1'b0, 1'b0, 32'd0);		// table full
		send(CMD_SET, 32'd0, 1'b0, 1'b0, 32'd0);		// zero delay wins over full
		send(CMD_CANCEL, 32'd0, 1'b0, 1'b0, 32'd3);		// periodic timer just freed
		repeat (3)
			send(CMD_TICK, 32'd0, 1'b0, 1'b0, 32'd0);
		drain();

		// Random phases: free running, idle sender, stalling receiver, both.
		for (int phase = 0; phase < 4; phase++) begin
			idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 22 : 0;
			stall_pct = (phase == 2) ? 84 : (phase == 3) ? 22 : 0;
			if (phase == 0 || phase == 3)
				fire_whole_table();
			n = 0;
			while (n < RANDOM_REQS) begin
				pick     = $urandom_range(99);
				delay    = $urandom();
				timer_id = $urandom();
				if (pick < 42) begin
					command = CMD_SET;
					case ($urandom_range(9))
						7:       delay = '0;
						8, 9:    delay = $urandom();
						default: delay = $urandom_range(7, 1);
					endcase
				end else if (pick < 80) begin
					command = CMD_TICK;
				end else if (pick < 96) begin
					command = CMD_CANCEL;
					case ($urandom_range(9))
						6:       timer_id = '0;
						7:       timer_id = sb.last_id + 1;	// not handed out yet
						8, 9:    timer_id = $urandom();
						default: timer_id = sb.any_live_id();
					endcase
				end else begin
					command = CMD_UNUSED;
				end
				send(command, delay, 1'($urandom()), 1'($urandom()), timer_id);
				if (command != CMD_UNUSED)
					n++;
			end
			drain();
		end

		// Let any late or spurious result show before the verdict.
		repeat (DRAIN_WAIT)
			@(posedge clk);
		if (sb.errors == 0 && sb.awaited_results.size() == 0)
			$display("multi_timer_scheduler_core_test: PASS");
		else
			$display("multi_timer_scheduler_core_test: FAIL");
		$finish;
	end

endmodule

FILE: multi_timer_scheduler_core.f
rtl/core/mts_pkg.sv
rtl/core/mts_if.sv
rtl/core/mts_front.sv
rtl/core/mts_engine.sv
rtl/core/multi_timer_scheduler_core.sv
rtl/core/mts_checker.sv
test/multi_timer_scheduler_core_test.sv
